[sv/sbh_pkg.sv]
// Shared types and constants of the SHA-1 byte stream hasher.
// Holds the queue item type, the queue depth and the SHA-1 constants.
// Depends on nothing.
package sbh_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int ROUNDS = 80;
	localparam int DIGEST_WORDS = 5;

	localparam logic [31:0] K_0 = 32'h5a827999;
	localparam logic [31:0] K_1 = 32'h6ed9eba1;
	localparam logic [31:0] K_2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_3 = 32'hca62c1d6;

	localparam logic [31:0] SHA_IV [DIGEST_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef struct packed {
		logic        finish;
		logic [7:0]  data;
		logic [31:0] byte_total;
	} cmd_t;

endpackage

[sv/sbh_front.sv]
// Front end of the hasher: accepts input items and turns them into queue commands.
// Counts message bytes so that a finish command carries the message length.
// Depends on sbh_pkg.
module sbh_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          action,
	input  logic [7:0]    data_byte,
	input  logic          q_full,
	output logic          q_push,
	output sbh_pkg::cmd_t q_item
);
	import sbh_pkg::*;

	logic [31:0] count_q;

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		q_item.finish = action;
		q_item.data = data_byte;
		q_item.byte_total = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			if (action) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + 32'd1;
			end
		end
	end

endmodule

[sv/sbh_queue.sv]
// Short command queue between the front end and the back end of the hasher.
// A small register file with read and write pointers and a fill count.
// Depends on sbh_pkg.
module sbh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sbh_pkg::cmd_t push_item,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output sbh_pkg::cmd_t head_item
);
	import sbh_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count exceeds depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue popped while empty");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on push");
`endif

endmodule

[sv/sbh_back.sv]
// Back end of the hasher: packs bytes, pads the message, runs the SHA-1 rounds
// one per cycle and presents the digest words in an output register.
// Depends on sbh_pkg.
module sbh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  sbh_pkg::cmd_t q_item,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [31:0]   digest_word,
	output logic [2:0]    word_index,
	output logic          last_word
);
	import sbh_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	localparam logic [1:0] PH_NONE = 2'd0;
	localparam logic [1:0] PH_ZERO = 2'd1;
	localparam logic [1:0] PH_LEN = 2'd2;

	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [5:0] LAST_OFFSET = 6'd63;

	logic [2:0]  state_q;
	logic [1:0]  phase_q;
	logic [5:0]  offset_q;
	logic [6:0]  round_q;
	logic [2:0]  word_q;
	logic [31:0] blk_q [16];
	logic [31:0] chain_q [DIGEST_WORDS];
	logic [31:0] work_q [DIGEST_WORDS];
	logic [63:0] len_q;
	logic        out_valid_q;
	logic [31:0] digest_q;
	logic [2:0]  index_q;
	logic        last_q;

	logic        push_en;
	logic [7:0]  push_byte;
	logic        out_load;
	logic        out_free;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;
	logic [31:0] sched;

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		push_en = 1'b0;
		push_byte = '0;
		unique case (state_q)
			ST_IDLE: begin
				push_en = q_valid;
				push_byte = q_item.finish ? PAD_MARK : q_item.data;
			end
			ST_PAD: begin
				push_en = 1'b1;
				push_byte = (phase_q == PH_LEN || offset_q == LEN_OFFSET) ? len_q[63:56] : 8'h00;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		b = work_q[1];
		c = work_q[2];
		d = work_q[3];
		priority if (round_q < 7'd20) begin
			f_val = d ^ (b & (c ^ d));
			k_val = K_0;
		end else if (round_q < 7'd40) begin
			f_val = b ^ c ^ d;
			k_val = K_1;
		end else if (round_q < 7'd60) begin
			f_val = (b & c) | (d & (b | c));
			k_val = K_2;
		end else begin
			f_val = b ^ c ^ d;
			k_val = K_3;
		end
		t_val = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4] + k_val + blk_q[0];
		sched = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
		sched = {sched[30:0], sched[31]};
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			for (int i = 0; i < 15; i++) begin
				blk_q[i] <= {blk_q[i][23:0], blk_q[i+1][31:24]};
			end
			blk_q[15] <= {blk_q[15][23:0], push_byte};
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				blk_q[i] <= blk_q[i+1];
			end
			blk_q[15] <= sched;
		end
		if (push_en && offset_q == LAST_OFFSET) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			work_q[4] <= work_q[3];
			work_q[3] <= work_q[2];
			work_q[2] <= {work_q[1][1:0], work_q[1][31:2]};
			work_q[1] <= work_q[0];
			work_q[0] <= t_val;
		end
		if (q_pop && q_item.finish) begin
			len_q <= {29'd0, q_item.byte_total, 3'd0};
		end else if (state_q == ST_PAD && push_byte == len_q[63:56]
			&& (phase_q == PH_LEN || offset_q == LEN_OFFSET)) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (out_load) begin
			digest_q <= chain_q[word_q];
			index_q <= word_q;
			last_q <= (word_q == 3'(DIGEST_WORDS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_NONE;
			offset_q <= '0;
			round_q <= '0;
			word_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				chain_q[i] <= SHA_IV[i];
			end
		end else begin
			if (push_en) begin
				offset_q <= offset_q + 6'd1;
				if (state_q == ST_PAD && (phase_q == PH_LEN || offset_q == LEN_OFFSET)) begin
					phase_q <= PH_LEN;
				end else if (state_q == ST_IDLE && q_item.finish) begin
					phase_q <= PH_ZERO;
				end
				if (offset_q == LAST_OFFSET) begin
					round_q <= '0;
					state_q <= ST_ROUND;
				end else if (state_q == ST_IDLE && q_item.finish) begin
					state_q <= ST_PAD;
				end
			end
			unique case (state_q)
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == 7'(ROUNDS - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < DIGEST_WORDS; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
					unique case (phase_q)
						PH_LEN:  state_q <= ST_OUT;
						PH_ZERO: state_q <= ST_PAD;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_OUT: begin
					if (out_free) begin
						if (word_q == 3'(DIGEST_WORDS - 1)) begin
							word_q <= '0;
							phase_q <= PH_NONE;
							state_q <= ST_IDLE;
							for (int i = 0; i < DIGEST_WORDS; i++) begin
								chain_q[i] <= SHA_IV[i];
							end
						end else begin
							word_q <= word_q + 3'd1;
						end
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign digest_word = digest_q;
	assign word_index = index_q;
	assign last_word = last_q;

`ifndef SYNTH
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q < 7'(ROUNDS)))
		else $error("round counter out of range");
	a_round_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (offset_q == '0))
		else $error("compression runs on a partial block");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (index_q == 3'(DIGEST_WORDS - 1)))
		else $error("last digest word carries a wrong index");
`endif

endmodule

[sv/sha1_byte_stream_hasher_core.sv]
// SHA-1 byte stream hasher, top level.
// Input channel: in_valid, in_stall, action, data_byte. An item is taken when
// in_valid is high and in_stall is low. Action 0 adds data_byte to the message;
// action 1 ends the message, pads it and produces the digest.
// Output channel: out_valid, out_stall, digest_word, word_index, last_word. A
// finish item yields five items, H0 first, last_word set on the fifth.
// A four-item queue sits between the front end and the back end, so input is
// taken while the back end compresses or waits on the output.
// The back end takes one data byte per cycle while idle. Each full 64-byte block
// then runs 80 rounds on the single round unit and a chaining add.
// A finish item pushes one pad byte per cycle (9 to 72 bytes), compresses each
// block it completes, then one digest word per cycle while the output is taken.
// The output register holds each word while out_stall is high; the next word is
// loaded only as the current one is taken.
// Reset clears the queue, the byte count and the block offset and loads the
// initial chaining vector. After a digest the block is ready for a new message.
// Depends on sbh_pkg, sbh_front, sbh_queue and sbh_back.
module sha1_byte_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sbh_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_not_empty;
	cmd_t push_item;
	cmd_t head_item;

	sbh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.data_byte (data_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	sbh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	sbh_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_not_empty),
		.q_item      (head_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule

[verif/tb_sha1_byte_stream_hasher_core.sv]
// Testbench for sha1_byte_stream_hasher_core: streams messages byte by byte,
// predicts every SHA-1 digest word in place and checks the output items.
// Depends on sbh_pkg and the sha1_byte_stream_hasher_core RTL.
`timescale 1ns / 100ps

module tb_sha1_byte_stream_hasher_core;

	import sbh_pkg::*;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_FINISH = 1'b1;
	localparam int RANDOM_ITEMS = 420;
	localparam int QUIET_TAIL = 60;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic       act;
		logic [7:0] data;
		bit         drain;
	} stim_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = ACT_BYTE;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	stim_t   stim_q[$];
	digest_t digest_expect[$];

	logic [31:0] sha_blk [16];
	logic [31:0] sha_chain [DIGEST_WORDS];
	logic [31:0] sha_len = '0;
	logic [5:0]  sha_off = '0;

	int mismatches = 0;
	int results_seen = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit idle_ok = 1'b1;
	int idle_cycles = 0;

	sha1_byte_stream_hasher_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic sha_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, t;
		int r;
		w = sha_blk;
		a = sha_chain[0];
		b = sha_chain[1];
		c = sha_chain[2];
		d = sha_chain[3];
		e = sha_chain[4];
		for (r = 0; r < ROUNDS; r++) begin
			if (r >= 16)
				w[r % 16] = rol(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16]
					^ w[r % 16], 1);
			if (r < 20)
				f = (d ^ (b & (c ^ d))) + K_0;
			else if (r < 40)
				f = (b ^ c ^ d) + K_1;
			else if (r < 60)
				f = ((b & c) | (d & (b | c))) + K_2;
			else
				f = (b ^ c ^ d) + K_3;
			t = f + rol(a, 5) + e + w[r % 16];
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		sha_chain[0] += a;
		sha_chain[1] += b;
		sha_chain[2] += c;
		sha_chain[3] += d;
		sha_chain[4] += e;
	endtask

	task automatic sha_put(input logic [7:0] v);
		sha_blk[sha_off[5:2]][8 * (3 - sha_off[1:0]) +: 8] = v;
		sha_off++;
		if (sha_off == 6'd0)
			sha_compress();
	endtask

	task automatic sha_finish();
		logic [31:0] n;
		digest_t dw;
		int k;
		n = sha_len;
		sha_put(PAD_MARK);
		while (sha_off != 6'd56)
			sha_put(8'h00);
		sha_put(8'h00);
		sha_put(8'h00);
		sha_put(8'h00);
		sha_put({5'b0, n[31:29]});
		sha_put(n[28:21]);
		sha_put(n[20:13]);
		sha_put(n[12:5]);
		sha_put({n[4:0], 3'b000});
		for (k = 0; k < DIGEST_WORDS; k++) begin
			dw.word = sha_chain[k];
			dw.idx = 3'(k);
			dw.last = (k == DIGEST_WORDS - 1);
			digest_expect.push_back(dw);
		end
		sha_chain = SHA_IV;
		sha_len = '0;
		sha_off = '0;
	endtask

	task automatic sha_step(input logic act, input logic [7:0] v);
		if (act == ACT_BYTE) begin
			sha_len++;
			sha_put(v);
		end else begin
			sha_finish();
		end
	endtask

	task automatic add_item(input logic act, input logic [7:0] v, input bit drain);
		stim_t s;
		s.act = act;
		s.data = v;
		s.drain = drain;
		stim_q.push_back(s);
	endtask

	task automatic add_message(input int len, input bit drain, inout int count);
		int i;
		for (i = 0; i < len; i++)
			add_item(ACT_BYTE, 8'($urandom), drain && i == 0);
		add_item(ACT_FINISH, 8'($urandom), drain && len == 0);
		count += len + 1;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		$display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		int count;
		int pick;
		int len;
		sha_chain = SHA_IV;
		add_item(ACT_FINISH, 8'h00, 1'b0);
		add_item(ACT_BYTE, 8'h61, 1'b0);
		add_item(ACT_BYTE, 8'h62, 1'b0);
		add_item(ACT_BYTE, 8'h63, 1'b0);
		add_item(ACT_FINISH, 8'h00, 1'b0);
		add_item(ACT_BYTE, 8'h00, 1'b0);
		add_item(ACT_BYTE, 8'hff, 1'b0);
		add_item(ACT_FINISH, 8'hff, 1'b0);
		add_item(ACT_FINISH, 8'h5a, 1'b0);
		count = 0;
		add_message(55, 1'b1, count);
		while (count < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				len = $urandom_range(0, 12);
			else if (pick < 8)
				len = $urandom_range(50, 70);
			else
				len = $urandom_range(0, 130);
			if (len > RANDOM_ITEMS - count - 1)
				len = RANDOM_ITEMS - count - 1;
			add_message(len, $urandom_range(0, 4) == 0, count);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_q.size() != 0 || in_valid || digest_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && digest_expect.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		stim_t nxt;
		logic nv;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sha_step(action, data_byte);
			if (!in_valid || !in_stall) begin
				nv = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (stim_q.size() != 0
					&& !(stim_q[0].drain && digest_expect.size() != 0)) begin
					if (idle_ok && $urandom_range(0, 9) == 0) begin
						send_gap = $urandom_range(0, 12);
					end else begin
						nxt = stim_q.pop_front();
						nv = 1'b1;
						action <= nxt.act;
						data_byte <= nxt.data;
					end
				end
				in_valid <= nv;
			end
			idle_ok <= stim_q.size() > QUIET_TAIL;
		end
	end

	always @(posedge clk) begin
		logic ns;
		if (arst_n) begin
			ns = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
				ns = 1'b1;
			end else if (!hold_done && results_seen >= 3 * DIGEST_WORDS) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				ns = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				ns = 1'b1;
			end else if (idle_ok && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 12);
				ns = 1'b1;
			end
			out_stall <= ns;
		end
	end

	always @(posedge clk) begin
		digest_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (digest_expect.size() == 0) begin
				report_mismatch("unexpected item", digest_word, '0);
			end else begin
				want = digest_expect.pop_front();
				if (digest_word !== want.word)
					report_mismatch("digest_word", digest_word, want.word);
				if (word_index !== want.idx)
					report_mismatch("word_index", 32'(word_index), 32'(want.idx));
				if (last_word !== want.last)
					report_mismatch("last_word", 32'(last_word), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
